### hw/rtl/keyword_substitution_cipher_unit_defines.svh
// assertion macros for the keyword substitution cipher unit
`ifndef KEYWORD_SUBSTITUTION_CIPHER_UNIT_DEFINES_SVH
`define KEYWORD_SUBSTITUTION_CIPHER_UNIT_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication, checked outside reset
`define KSC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, checked outside reset
`define KSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define KSC_ASSERT_IMPL(label, ante, cons, msg)
`define KSC_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### hw/rtl/ksc_pkg.sv
// shared types and constants for the keyword substitution cipher unit
package ksc_pkg;

    typedef logic [7:0] char_t;
    typedef logic [4:0] letter_t;
    typedef logic [2:0] cfg_idx_t;

    localparam int KEY_LEN   = 5;
    localparam int ALPHA_LEN = 26;

    localparam letter_t LETTER_MAX = 5'd25;

    localparam char_t CHAR_LO_A = 8'h61;
    localparam char_t CHAR_LO_Z = 8'h7a;
    localparam char_t CHAR_UP_A = 8'h41;
    localparam char_t CHAR_UP_Z = 8'h5a;
    localparam char_t CHAR_SPACE = 8'h20;
    localparam char_t CHAR_TAB   = 8'h09;
    localparam char_t CHAR_CR    = 8'h0d;
    localparam char_t CHAR_DEL   = 8'h7f;

    localparam logic ACT_ENCRYPT = 1'b0;
    localparam logic ACT_DECRYPT = 1'b1;

endpackage

### hw/rtl/keyword_substitution_cipher_unit.sv
// keyword substitution cipher unit, top level
// an accepted input transaction passes through stages 1, 2 and 3 and then the output register to char_out
// throughput: one transaction per cycle through four registered stages that hold on stall
// bytes other than letters and whitespace are dropped in stage 1 and give no output
// reset: async active-low clears all valid bits and loads key letters a, b, c, d, e
`include "keyword_substitution_cipher_unit_defines.svh"

module keyword_substitution_cipher_unit (
    input  logic              clk,
    input  logic              rst_n,
    // configuration write port
    input  logic              cfg_wr_en,
    input  ksc_pkg::cfg_idx_t cfg_index,
    input  ksc_pkg::letter_t  cfg_data,
    // input channel
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              action,
    input  ksc_pkg::char_t    char_in,
    // output channel
    output logic              out_valid,
    input  logic              out_stall,
    output ksc_pkg::char_t    char_out
);

    import ksc_pkg::*;

    // key letters, saturated to 'z' on write
    letter_t key_reg [KEY_LEN];

    // stage 1: classify byte, letter position, non-key mask, key hits
    logic                 v1_reg;
    logic                 act1_reg;
    logic                 letter1_reg;
    logic                 upper1_reg;
    char_t                ch1_reg;
    letter_t              pos1_reg;
    logic [ALPHA_LEN-1:0] mask1_reg;
    logic [KEY_LEN-1:0]   hit1_reg;

    // stage 2: rank of each letter within the non-key list
    logic                 v2_reg;
    logic                 act2_reg;
    logic                 letter2_reg;
    logic                 upper2_reg;
    char_t                ch2_reg;
    letter_t              pos2_reg;
    logic [ALPHA_LEN-1:0] mask2_reg;
    logic [KEY_LEN-1:0]   hit2_reg;
    letter_t              rank2_reg [ALPHA_LEN];

    // stage 3: substituted letter index
    logic                 v3_reg;
    logic                 letter3_reg;
    logic                 upper3_reg;
    char_t                ch3_reg;
    letter_t              idx3_reg;

    // stage 4: output register
    logic                 out_valid_reg;
    char_t                char_out_reg;

    // per-stage advance: a stage loads when it is empty or its successor loads
    logic en1, en2, en3, en4;

    assign en4      = !out_valid_reg || !out_stall;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_stall = !en1;

    assign out_valid = out_valid_reg;
    assign char_out  = char_out_reg;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEY_LEN; i++)
            begin
                key_reg[i] <= letter_t'(i);
            end
        end
        else if (cfg_wr_en && (cfg_index < cfg_idx_t'(KEY_LEN)))
        begin
            key_reg[cfg_index] <= (cfg_data > LETTER_MAX) ? LETTER_MAX : cfg_data;
        end
    end

    // ---------------- stage 1 ----------------
    logic                 lower_in;
    logic                 upper_in;
    logic                 space_in;
    logic                 keep_in;
    letter_t              pos1_next;
    logic [ALPHA_LEN-1:0] mask1_next;
    logic [KEY_LEN-1:0]   hit1_next;

    always_comb
    begin
        lower_in  = (char_in >= CHAR_LO_A) && (char_in <= CHAR_LO_Z);
        upper_in  = (char_in >= CHAR_UP_A) && (char_in <= CHAR_UP_Z);
        space_in  = (char_in == CHAR_SPACE) || ((char_in >= CHAR_TAB) && (char_in <= CHAR_CR));
        keep_in   = lower_in || upper_in || space_in;
        // 'a' and 'A' both sit at 1 in the low five bits
        pos1_next = char_in[4:0] - 5'd1;
        for (int c = 0; c < ALPHA_LEN; c++)
        begin
            mask1_next[c] = 1'b1;
            for (int i = 0; i < KEY_LEN; i++)
            begin
                if (key_reg[i] == letter_t'(c))
                begin
                    mask1_next[c] = 1'b0;
                end
            end
        end
        for (int i = 0; i < KEY_LEN; i++)
        begin
            hit1_next[i] = (key_reg[i] == pos1_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en1)
        begin
            v1_reg <= in_valid && keep_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            act1_reg    <= action;
            letter1_reg <= lower_in || upper_in;
            upper1_reg  <= upper_in;
            ch1_reg     <= char_in;
            pos1_reg    <= pos1_next;
            mask1_reg   <= mask1_next;
            hit1_reg    <= hit1_next;
        end
    end

    // ---------------- stage 2 ----------------
    // rank of letter c = c minus the number of distinct key letters below c
    logic [KEY_LEN-1:0] uniq;
    logic [2:0]         below_cnt [ALPHA_LEN];
    letter_t            rank2_next [ALPHA_LEN];

    always_comb
    begin
        for (int i = 0; i < KEY_LEN; i++)
        begin
            uniq[i] = 1'b1;
            for (int j = 0; j < KEY_LEN; j++)
            begin
                if ((j < i) && (key_reg[j] == key_reg[i]))
                begin
                    uniq[i] = 1'b0;
                end
            end
        end
        for (int c = 0; c < ALPHA_LEN; c++)
        begin
            below_cnt[c] = 3'd0;
            for (int i = 0; i < KEY_LEN; i++)
            begin
                if (uniq[i] && (key_reg[i] < letter_t'(c)))
                begin
                    below_cnt[c] = below_cnt[c] + 3'd1;
                end
            end
            rank2_next[c] = letter_t'(c) - {2'b00, below_cnt[c]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en2)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            act2_reg    <= act1_reg;
            letter2_reg <= letter1_reg;
            upper2_reg  <= upper1_reg;
            ch2_reg     <= ch1_reg;
            pos2_reg    <= pos1_reg;
            mask2_reg   <= mask1_reg;
            hit2_reg    <= hit1_reg;
            for (int c = 0; c < ALPHA_LEN; c++)
            begin
                rank2_reg[c] <= rank2_next[c];
            end
        end
    end

    // ---------------- stage 3 ----------------
    letter_t              enc_pos;
    logic [ALPHA_LEN-1:0] enc_sel;
    letter_t              enc_nk;
    logic [2:0]           dec_key;
    letter_t              dec_nk;
    letter_t              idx3_next;

    always_comb
    begin
        // encrypt beyond the key: pick the non-key letter whose rank matches
        enc_pos = pos2_reg - letter_t'(KEY_LEN);
        enc_nk  = '0;
        for (int c = 0; c < ALPHA_LEN; c++)
        begin
            enc_sel[c] = mask2_reg[c] && (rank2_reg[c] == enc_pos);
            if (enc_sel[c])
            begin
                enc_nk = enc_nk | letter_t'(c);
            end
        end
        // decrypt a key letter: first key slot that holds it
        dec_key = 3'd0;
        for (int i = KEY_LEN - 1; i >= 0; i--)
        begin
            if (hit2_reg[i])
            begin
                dec_key = 3'(i);
            end
        end
        // decrypt a non-key letter: its place after the key
        if (pos2_reg <= LETTER_MAX)
        begin
            dec_nk = rank2_reg[pos2_reg] + letter_t'(KEY_LEN);
        end
        else
        begin
            dec_nk = '0;
        end
        case (act2_reg)
            ACT_ENCRYPT:
            begin
                if (pos2_reg < letter_t'(KEY_LEN))
                begin
                    idx3_next = key_reg[pos2_reg[2:0]];
                end
                else
                begin
                    idx3_next = enc_nk;
                end
            end
            ACT_DECRYPT:
            begin
                if (|hit2_reg)
                begin
                    idx3_next = {2'b00, dec_key};
                end
                else
                begin
                    idx3_next = dec_nk;
                end
            end
            default:
            begin
                idx3_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en3)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            letter3_reg <= letter2_reg;
            upper3_reg  <= upper2_reg;
            ch3_reg     <= ch2_reg;
            idx3_reg    <= idx3_next;
        end
    end

    // ---------------- stage 4 ----------------
    char_t char_out_next;

    always_comb
    begin
        if (letter3_reg)
        begin
            char_out_next = (upper3_reg ? CHAR_UP_A : CHAR_LO_A) + {3'b000, idx3_reg};
        end
        else
        begin
            char_out_next = ch3_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en4)
        begin
            out_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            char_out_reg <= char_out_next;
        end
    end

    // ---------------- assertions ----------------
    `KSC_ASSERT_NEXT(a_letter_enters, in_valid && !in_stall && (lower_in || upper_in), v1_reg, "accepted letter did not enter stage 1")
    `KSC_ASSERT_NEXT(a_stage3_holds, v3_reg && !en3, v3_reg, "stage 3 transaction lost while held")
    `KSC_ASSERT_IMPL(a_enc_sel_onehot, v2_reg && letter2_reg && (act2_reg == ACT_ENCRYPT) && (pos2_reg >= letter_t'(KEY_LEN)), $onehot(enc_sel), "non-key letter select not one-hot")
    `KSC_ASSERT_IMPL(a_key_range, 1'b1, (key_reg[0] <= LETTER_MAX) && (key_reg[1] <= LETTER_MAX) && (key_reg[2] <= LETTER_MAX) && (key_reg[3] <= LETTER_MAX) && (key_reg[4] <= LETTER_MAX), "key letter out of range")
    `KSC_ASSERT_IMPL(a_out_code, out_valid_reg, (char_out_reg == CHAR_SPACE) || ((char_out_reg >= CHAR_TAB) && (char_out_reg <= CHAR_CR)) || ((char_out_reg >= CHAR_UP_A) && (char_out_reg <= CHAR_DEL)), "output byte outside expected codes")

endmodule
